// ===== rtl/segtree_pkg.sv =====
// shared constants for the segment tree range-sum block
`timescale 1ns / 1ps
package segtree_pkg;
	localparam int LEAVES_DEF = 1024;
	localparam int FUNC_W     = 1;
	localparam int INDEX_W    = 10;
	localparam int VALUE_W    = 32;
	localparam int RIGHT_W    = 11;
	localparam int SUM_W      = 64;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_SET = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_SUM = 1'b1;
endpackage

// ===== rtl/segtree_ram.sv =====
// generic simple dual-port ram with one write port and a registered read port
`timescale 1ns / 1ps
module segtree_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/segment_tree_point_set_range_sum.sv =====
// segment tree with point set and half-open range sum over signed leaves
// a set keeps busy high while it rewrites the ancestors of the leaf, one tree level per cycle
// a query keeps busy high while its range is open, bounded by
//   the single memory read port (at most two node reads and one shift step per level)
// only one transaction at a time; done is a registered pulse raised when a query finishes
// reset: after arst_n the node memory is cleared by a pass over all 2*LEAVES nodes, busy high
`timescale 1ns / 1ps
module segment_tree_point_set_range_sum #(
	parameter int LEAVES = segtree_pkg::LEAVES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [segtree_pkg::FUNC_W-1:0]    func,
	input  logic [segtree_pkg::INDEX_W-1:0]   index,
	input  logic signed [segtree_pkg::VALUE_W-1:0] value,
	input  logic [segtree_pkg::RIGHT_W-1:0]   right_end,
	output logic                              done,
	output logic signed [segtree_pkg::SUM_W-1:0] range_sum
);
	import segtree_pkg::*;

	// node address width: nodes 0 .. 2*LEAVES-1
	localparam int AW    = $clog2(LEAVES) + 1;
	localparam int DEPTH = 2 * LEAVES;
	// compare width, wide enough for both the input fields and 2*LEAVES
	localparam int EW    = (AW + 1 > RIGHT_W + 1) ? AW + 1 : RIGHT_W + 1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET,
		ST_SUM
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;     // clearing pass address
	logic [AW-1:0]     cur_q;     // node just written during a set walk
	logic [SUM_W-1:0]  val_q;     // value just written at cur_q
	logic [AW:0]       lo_q;      // query left bound, node domain
	logic [AW:0]       hi_q;      // query right bound (exclusive), node domain
	logic [SUM_W-1:0]  acc_q;
	logic              pend_s1;   // a node read issued last cycle is to be added
	logic              done_q;
	logic [SUM_W-1:0]  range_sum_q;

	// memory port
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [SUM_W-1:0]  mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [SUM_W-1:0]  mem_rdata;

	// request decode
	logic [EW-1:0]     idx_w;
	logic [EW-1:0]     rend_w;
	logic [EW-1:0]     leaves_w;
	logic [EW-1:0]     hi_clamp;
	logic              set_ok;
	logic              sum_empty;
	logic [AW-1:0]     leaf_node;
	logic [SUM_W-1:0]  value_ext;
	logic              accept;

	// walk datapath
	logic [AW-1:0]     parent;
	logic [SUM_W-1:0]  parent_sum;
	logic              sum_live;
	logic              sum_rd;
	logic [AW:0]       hi_dec;
	logic [SUM_W-1:0]  acc_next;

	assign accept    = start && !busy;
	assign idx_w     = EW'(index);
	assign rend_w    = EW'(right_end);
	assign leaves_w  = EW'(LEAVES);
	assign hi_clamp  = (rend_w > leaves_w) ? leaves_w : rend_w;
	assign set_ok    = idx_w < leaves_w;
	assign sum_empty = idx_w >= hi_clamp;
	// only used when the index lies inside the tree, so the sum fits
	assign leaf_node = AW'(idx_w + leaves_w);
	assign value_ext = {{(SUM_W - VALUE_W){value[VALUE_W-1]}}, value};

	// set walk: parent takes the written child plus its sibling read last cycle
	assign parent     = cur_q >> 1;
	assign parent_sum = val_q + mem_rdata;

	// query walk: one read or one shift per cycle while the range is open
	assign sum_live = lo_q < hi_q;
	assign sum_rd   = sum_live && (lo_q[0] || hi_q[0]);
	assign hi_dec   = hi_q - (AW + 1)'(1);
	assign acc_next = pend_s1 ? acc_q + mem_rdata : acc_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = cur_q ^ AW'(1);
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_waddr = leaf_node;
				mem_wdata = value_ext;
				mem_raddr = leaf_node ^ AW'(1);
				if (accept && func == FUNC_SET && set_ok) begin
					mem_we = 1'b1;
				end
			end
			ST_SET: begin
				mem_we    = 1'b1;
				mem_waddr = parent;
				mem_wdata = parent_sum;
				mem_raddr = parent ^ AW'(1);
			end
			ST_SUM: begin
				mem_raddr = lo_q[0] ? lo_q[AW-1:0] : hi_dec[AW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			val_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			acc_q       <= '0;
			pend_s1     <= 1'b0;
			done_q      <= 1'b0;
			range_sum_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					acc_q   <= '0;
					cur_q   <= leaf_node;
					val_q   <= value_ext;
					lo_q    <= (AW + 1)'(idx_w + leaves_w);
					hi_q    <= (AW + 1)'(hi_clamp + leaves_w);
					if (accept) begin
						if (func == FUNC_SUM) begin
							if (sum_empty) begin
								done_q      <= 1'b1;
								range_sum_q <= '0;
							end else begin
								state_q <= ST_SUM;
							end
						end else if (set_ok) begin
							state_q <= ST_SET;
						end
					end
				end
				ST_SET: begin
					cur_q <= parent;
					val_q <= parent_sum;
					if (parent == AW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					acc_q   <= acc_next;
					pend_s1 <= sum_rd;
					if (!sum_live) begin
						// range closed: fold in the last read and report
						done_q      <= 1'b1;
						range_sum_q <= acc_next;
						state_q     <= ST_IDLE;
					end else if (lo_q[0]) begin
						lo_q <= lo_q + (AW + 1)'(1);
					end else if (hi_q[0]) begin
						hi_q <= hi_dec;
					end else begin
						lo_q <= lo_q >> 1;
						hi_q <= hi_q >> 1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	segtree_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_nodes (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign busy      = state_q != ST_IDLE;
	assign done      = done_q;
	assign range_sum = range_sum_q;
endmodule

// ===== tb/segment_tree_point_set_range_sum_test.sv =====
// self-checking testbench for the segment tree point set / range sum block
`timescale 1ns / 1ps
module segment_tree_point_set_range_sum_test;
	import segtree_pkg::*;

	localparam int LEAVES = LEAVES_DEF;
	localparam int RIGHT_MAX = (1 << RIGHT_W) - 1;

	// one query result waiting to come back, with its range for the log
	typedef struct {
		logic [INDEX_W-1:0] lo;
		logic [RIGHT_W-1:0] hi;
		logic [SUM_W-1:0]   sum;
	} sum_expect_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [FUNC_W-1:0]         func = FUNC_SET;
	logic [INDEX_W-1:0]        index = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic [RIGHT_W-1:0]        right_end = '0;
	logic                      done;
	logic signed [SUM_W-1:0]   range_sum;

	// shadow copy of the node sums: leaves at LEAVES..2*LEAVES-1, node k = 2k + 2k+1
	logic [SUM_W-1:0] tree_sums [2*LEAVES];
	sum_expect_t      pending_sums [$];
	int               err_count = 0;
	bit               gaps_on = 1'b1;

	segment_tree_point_set_range_sum #(
		.LEAVES(LEAVES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.index(index),
		.value(value),
		.right_end(right_end),
		.done(done),
		.range_sum(range_sum)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// overall watchdog, far beyond the slowest legal run including the clearing pass
	initial begin
		#5_000_000;
		$display("segment_tree_point_set_range_sum_test NOT OK");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $realtime, what);
		err_count++;
	endtask

	// write one leaf (sign-extended) and rebuild every ancestor, wrapping mod 2^64
	function automatic void tree_write(input int unsigned leaf, input logic signed [VALUE_W-1:0] v);
		int unsigned k;
		k = leaf + LEAVES;
		tree_sums[k] = {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
		k = k >> 1;
		while (k >= 1) begin
			tree_sums[k] = tree_sums[2*k] + tree_sums[2*k+1];
			k = k >> 1;
		end
	endfunction

	// bottom-up sum over [lo, hi), right end clamped to the tree, empty range gives zero
	function automatic logic [SUM_W-1:0] tree_range_sum(input int unsigned lo,
		input int unsigned hi);
		logic [SUM_W-1:0] acc;
		acc = '0;
		if (hi > LEAVES)
			hi = LEAVES;
		if (lo >= hi)
			return '0;
		lo += LEAVES;
		hi += LEAVES;
		while (lo < hi) begin
			if ((lo & 1) != 0) begin
				acc += tree_sums[lo];
				lo++;
			end
			if ((hi & 1) != 0) begin
				hi--;
				acc += tree_sums[hi];
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	// leaf values weighted toward the extremes and small magnitudes
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			4: return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
			default: return $urandom;
		endcase
	endfunction

	// one transaction: optional idle burst, then hold start until the block takes it
	task automatic send_op(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
		input logic signed [VALUE_W-1:0] val, input logic [RIGHT_W-1:0] rend);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		start     <= 1'b1;
		func      <= f;
		index     <= idx;
		value     <= val;
		right_end <= rend;
		do
			@(posedge clk);
		while (busy);
		// taken at this edge: update the shadow tree or queue the sum the query must return
		if (f == FUNC_SET)
			tree_write(32'(idx), val);
		else
			pending_sums.push_back('{lo: idx, hi: rend,
				sum: tree_range_sum(32'(idx), 32'(rend))});
	endtask

	// hold off new work until every outstanding query result is back
	task automatic wait_results_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_sums.size() != 0);
	endtask

	// done is high for one cycle only; results are taken at the edge that ends it
	always @(posedge clk) begin
		sum_expect_t head;
		if (arst_n && done) begin
			if (pending_sums.size() == 0) begin
				flag_mismatch($sformatf("range_sum %0d with no query waiting", range_sum));
			end else begin
				head = pending_sums.pop_front();
				if (range_sum !== head.sum)
					flag_mismatch($sformatf("sum [%0d,%0d) got %0d want %0d", head.lo,
						head.hi, range_sum, $signed(head.sum)));
			end
		end
	end

	// queries against the freshly cleared tree
	task automatic test_cleared_tree();
		send_op(FUNC_SUM, 10'd0, '0, RIGHT_W'(LEAVES));
		send_op(FUNC_SUM, 10'd5, '0, 11'd6);
		send_op(FUNC_SUM, 10'd0, '0, RIGHT_W'(RIGHT_MAX));
	endtask

	// extreme values at the tree edges, ignored fields, right end clamping
	task automatic test_leaf_extremes();
		send_op(FUNC_SET, 10'd0, 32'sh7FFF_FFFF, 11'd0);
		send_op(FUNC_SET, 10'd1023, 32'sh8000_0000, 11'd0);
		send_op(FUNC_SET, 10'd512, -32'sd1, 11'd0);
		// right end is ignored by a set
		send_op(FUNC_SET, 10'd1, 32'sd1, RIGHT_W'(RIGHT_MAX));
		send_op(FUNC_SUM, 10'd0, '0, RIGHT_W'(LEAVES));
		send_op(FUNC_SUM, 10'd0, '0, 11'd1);
		send_op(FUNC_SUM, 10'd1023, '0, RIGHT_W'(LEAVES));
		send_op(FUNC_SUM, 10'd0, '0, 11'd1023);
		// value is ignored by a query
		send_op(FUNC_SUM, 10'd1, -32'sd1, RIGHT_W'(LEAVES));
		// right end just past and far past the last leaf
		send_op(FUNC_SUM, 10'd0, '0, RIGHT_W'(LEAVES + 1));
		send_op(FUNC_SUM, 10'd1000, 32'sh7FFF_FFFF, RIGHT_W'(RIGHT_MAX));
	endtask

	// empty and inverted ranges must give zero on a non-zero tree
	task automatic test_empty_ranges();
		send_op(FUNC_SUM, 10'd7, '0, 11'd7);
		send_op(FUNC_SUM, 10'd600, '0, 11'd10);
		send_op(FUNC_SUM, 10'd1023, '0, 11'd0);
		send_op(FUNC_SUM, 10'd0, '0, 11'd0);
		send_op(FUNC_SUM, 10'd1023, '0, 11'd1023);
	endtask

	// rewriting a leaf replaces its value rather than adding to it
	task automatic test_overwrite();
		send_op(FUNC_SET, 10'd0, '0, 11'd0);
		send_op(FUNC_SET, 10'd1023, -32'sd5, 11'd0);
		send_op(FUNC_SUM, 10'd1022, '0, RIGHT_W'(LEAVES));
		send_op(FUNC_SUM, 10'd0, '0, RIGHT_W'(LEAVES));
	endtask

	// random sets and queries; ranges mostly inside the tree, some clamped, some empty
	task automatic test_random_mix(input int n_items, input bit allow_gaps);
		int i;
		int lo;
		int hi;
		logic [FUNC_W-1:0] f;
		gaps_on = 1'b0;
		for (i = 0; i < n_items; i++) begin
			// idle bursts come and go in stretches
			if (allow_gaps && i % 64 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			// once in the middle, let the pipe run dry before going on
			if (allow_gaps && i == n_items / 2)
				wait_results_drained();
			lo = $urandom_range(0, LEAVES - 1);
			case ($urandom_range(0, 5))
				0: hi = $urandom_range(0, RIGHT_MAX);
				1: hi = lo + $urandom_range(1, 16);
				2: hi = LEAVES;
				3: hi = $urandom_range(0, lo);
				default: hi = $urandom_range(lo, LEAVES);
			endcase
			f = ($urandom_range(0, 1) == 0) ? FUNC_SET : FUNC_SUM;
			send_op(f, lo[INDEX_W-1:0], pick_value(), hi[RIGHT_W-1:0]);
		end
	endtask

	initial begin
		int waited;
		foreach (tree_sums[k])
			tree_sums[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_tree();
		test_leaf_extremes();
		test_empty_ranges();
		test_overwrite();
		wait_results_drained();
		test_random_mix(1250, 1'b1);
		// back-to-back transactions, no idling at all
		test_random_mix(680, 1'b0);

		start <= 1'b0;
		waited = 0;
		while (pending_sums.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		// a trailing set may still be walking the tree
		repeat (40) @(posedge clk);
		if (pending_sums.size() != 0)
			flag_mismatch($sformatf("%0d query results never came", pending_sums.size()));

		if (err_count == 0)
			$display("segment_tree_point_set_range_sum_test OK");
		else
			$display("segment_tree_point_set_range_sum_test NOT OK");
		$finish;
	end
endmodule
